// File: src/llof_pkg.sv
package llof_pkg;

   // default frame limits
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   // fixed field widths
   localparam int COORD_W    = 10;
   localparam int CFG_SIZE_W = 11;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_MODE   = 2'd0,
      REG_WIDTH  = 2'd1,
      REG_HEIGHT = 2'd2
   } reg_index_type;

   typedef enum logic {
      DIR_HORIZONTAL = 1'b0,
      DIR_VERTICAL   = 1'b1
   } dir_type;

   // per-pixel control handed to the run tracker
   typedef struct packed {
      logic valid;
      logic pixel;
      logic first_row;
      logic first_col;
      logic frame_end;
   } pix_ctrl_type;

   // result queue occupancy
   typedef struct packed {
      logic head_valid;
      logic tail_valid;
   } queue_status_type;

endpackage

// File: src/llof_col_mem.sv
// Column line memory: run length and start row per column.
// Registered read, write-through forwarding, fill count in place of a clear.
module llof_col_mem #(
   parameter int  MAX_WIDTH  = llof_pkg::DEF_MAX_WIDTH,
   parameter int  MAX_HEIGHT = llof_pkg::DEF_MAX_HEIGHT,
   localparam int CW         = $clog2(MAX_WIDTH),
   localparam int RW         = $clog2(MAX_HEIGHT),
   localparam int LEN_W      = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [CW-1:0]       rd_col,
   output logic [LEN_W-1:0]    rd_len,
   output logic [RW-1:0]       rd_start,
   input  logic                wr_en,
   input  logic [CW-1:0]       wr_col,
   input  logic [LEN_W-1:0]    wr_len,
   input  logic [RW-1:0]       wr_start
);

   localparam int ENTRY_W = LEN_W + RW;
   localparam int FILL_W  = $clog2(MAX_WIDTH + 1);

   logic [ENTRY_W-1:0] mem [MAX_WIDTH];
   logic [ENTRY_W-1:0] q_ff;
   logic [ENTRY_W-1:0] fwd_data_ff;
   logic               fwd_ff;
   logic               fwd_in;
   logic               zero_ff;
   logic               zero_in;
   logic [FILL_W-1:0]  fill_ff;
   logic [FILL_W-1:0]  fill_in;

   // same entry written this cycle: take the new value
   assign fwd_in  = wr_en && (wr_col == rd_col);
   // columns never written since reset read as zero
   assign zero_in = {{(FILL_W-CW){1'b0}}, rd_col} >= fill_ff;

   always_comb begin
      fill_in = fill_ff;
      if (wr_en && ({{(FILL_W-CW){1'b0}}, wr_col} == fill_ff)) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_col] <= {wr_len, wr_start};
      end
      if (rd_en) begin
         q_ff        <= mem[rd_col];
         fwd_data_ff <= {wr_len, wr_start};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         fwd_ff  <= 1'b0;
         zero_ff <= 1'b1;
      end else begin
         fill_ff <= fill_in;
         if (rd_en) begin
            fwd_ff  <= fwd_in;
            zero_ff <= zero_in;
         end
      end
   end

   always_comb begin
      if (fwd_ff) begin
         rd_len   = fwd_data_ff[ENTRY_W-1:RW];
         rd_start = fwd_data_ff[RW-1:0];
      end else if (zero_ff) begin
         rd_len   = '0;
         rd_start = '0;
      end else begin
         rd_len   = q_ff[ENTRY_W-1:RW];
         rd_start = q_ff[RW-1:0];
      end
   end

endmodule

// File: src/llof_run_track.sv
// Run tracker: second pipeline stage. Completes the column read-modify-write,
// extends the row run and keeps the best run of the frame.
module llof_run_track #(
   parameter int  MAX_WIDTH  = llof_pkg::DEF_MAX_WIDTH,
   parameter int  MAX_HEIGHT = llof_pkg::DEF_MAX_HEIGHT,
   localparam int CW         = $clog2(MAX_WIDTH),
   localparam int RW         = $clog2(MAX_HEIGHT),
   localparam int LEN_W      = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  llof_pkg::pix_ctrl_type acc_ctrl,
   input  logic [RW-1:0]          acc_row,
   input  logic [CW-1:0]          acc_col,
   input  llof_pkg::dir_type      mode,
   input  logic [LEN_W-1:0]       rd_len,
   input  logic [RW-1:0]          rd_start,
   output logic                   wr_en,
   output logic [CW-1:0]          wr_col,
   output logic [LEN_W-1:0]       wr_len,
   output logic [RW-1:0]          wr_start,
   output logic                   res_push,
   output logic [LEN_W-1:0]       res_len,
   output logic [RW-1:0]          res_sr,
   output logic [CW-1:0]          res_sc,
   output llof_pkg::dir_type      res_mode
);

   llof_pkg::pix_ctrl_type s1_ff;
   logic [RW-1:0]          s1_row_ff;
   logic [CW-1:0]          s1_col_ff;
   logic [LEN_W-1:0]       row_run_ff;
   logic [LEN_W-1:0]       row_run_in;
   logic [CW-1:0]          row_start_ff;
   logic [CW-1:0]          row_start_in;
   logic [LEN_W-1:0]       best_len_ff;
   logic [LEN_W-1:0]       best_len_in;
   logic [RW-1:0]          best_sr_ff;
   logic [RW-1:0]          best_sr_in;
   logic [CW-1:0]          best_sc_ff;
   logic [CW-1:0]          best_sc_in;

   logic [LEN_W-1:0] prev_h;
   logic [LEN_W-1:0] hlen;
   logic [CW-1:0]    hstart;
   logic [LEN_W-1:0] prev_v;
   logic [LEN_W-1:0] vlen;
   logic [RW-1:0]    vstart;
   logic [LEN_W-1:0] cand_len;
   logic [RW-1:0]    cand_sr;
   logic [CW-1:0]    cand_sc;
   logic             take;
   logic [LEN_W-1:0] next_len;
   logic [RW-1:0]    next_sr;
   logic [CW-1:0]    next_sc;

   always_comb begin
      // horizontal run
      prev_h = s1_ff.first_col ? '0 : row_run_ff;
      hlen   = s1_ff.pixel ? prev_h + LEN_W'(1) : '0;
      hstart = (prev_h == '0) ? s1_col_ff : row_start_ff;

      // vertical run
      prev_v = s1_ff.first_row ? '0 : rd_len;
      vlen   = s1_ff.pixel ? prev_v + LEN_W'(1) : '0;
      vstart = (s1_ff.pixel && (prev_v != '0)) ? rd_start : s1_row_ff;

      if (mode == llof_pkg::DIR_VERTICAL) begin
         cand_len = vlen;
         cand_sr  = vstart;
         cand_sc  = s1_col_ff;
      end else begin
         cand_len = hlen;
         cand_sr  = s1_row_ff;
         cand_sc  = hstart;
      end

      // longer wins; a tie goes to the earlier start in raster order
      take = (cand_len != '0) &&
             ((cand_len > best_len_ff) ||
              ((cand_len == best_len_ff) &&
               ((cand_sr < best_sr_ff) ||
                ((cand_sr == best_sr_ff) && (cand_sc < best_sc_ff)))));

      next_len = take ? cand_len : best_len_ff;
      next_sr  = take ? cand_sr  : best_sr_ff;
      next_sc  = take ? cand_sc  : best_sc_ff;

      row_run_in   = row_run_ff;
      row_start_in = row_start_ff;
      best_len_in  = best_len_ff;
      best_sr_in   = best_sr_ff;
      best_sc_in   = best_sc_ff;
      if (s1_ff.valid) begin
         row_run_in   = hlen;
         row_start_in = hstart;
         if (s1_ff.frame_end) begin
            best_len_in = '0;
            best_sr_in  = '0;
            best_sc_in  = '0;
         end else begin
            best_len_in = next_len;
            best_sr_in  = next_sr;
            best_sc_in  = next_sc;
         end
      end
   end

   assign wr_en    = s1_ff.valid;
   assign wr_col   = s1_col_ff;
   assign wr_len   = vlen;
   assign wr_start = vstart;

   assign res_push = s1_ff.valid && s1_ff.frame_end;
   assign res_len  = next_len;
   assign res_sr   = next_sr;
   assign res_sc   = next_sc;
   assign res_mode = mode;

   always_ff @(posedge clock) begin
      s1_row_ff    <= acc_row;
      s1_col_ff    <= acc_col;
      row_start_ff <= row_start_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff       <= '0;
         row_run_ff  <= '0;
         best_len_ff <= '0;
         best_sr_ff  <= '0;
         best_sc_ff  <= '0;
      end else begin
         s1_ff       <= acc_ctrl;
         row_run_ff  <= row_run_in;
         best_len_ff <= best_len_in;
         best_sr_ff  <= best_sr_in;
         best_sc_ff  <= best_sc_in;
      end
   end

endmodule

// File: src/llof_res_queue.sv
// Two-entry result queue: output register plus skid entry.
// End coordinates are formed from the registered head entry.
module llof_res_queue #(
   parameter int  MAX_WIDTH  = llof_pkg::DEF_MAX_WIDTH,
   parameter int  MAX_HEIGHT = llof_pkg::DEF_MAX_HEIGHT,
   localparam int CW         = $clog2(MAX_WIDTH),
   localparam int RW         = $clog2(MAX_HEIGHT),
   localparam int LEN_W      = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [LEN_W-1:0]             push_len,
   input  logic [RW-1:0]                push_sr,
   input  logic [CW-1:0]                push_sc,
   input  llof_pkg::dir_type            push_mode,
   output llof_pkg::queue_status_type   status,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_found,
   output logic [llof_pkg::COORD_W-1:0] rsp_start_row,
   output logic [llof_pkg::COORD_W-1:0] rsp_start_col,
   output logic [llof_pkg::COORD_W-1:0] rsp_end_row,
   output logic [llof_pkg::COORD_W-1:0] rsp_end_col
);

   localparam int MAX_A = (RW > CW) ? RW : CW;
   localparam int MAX_B = (MAX_A > LEN_W) ? MAX_A : LEN_W;
   localparam int SUM_W = ((MAX_B > llof_pkg::COORD_W) ? MAX_B : llof_pkg::COORD_W) + 1;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [RW-1:0]     sr;
      logic [CW-1:0]     sc;
      llof_pkg::dir_type mode;
   } entry_type;

   entry_type head_ff, head_in, tail_ff, tail_in, push_entry;
   logic      head_valid_ff, head_valid_in;
   logic      tail_valid_ff, tail_valid_in;
   logic      taken;

   logic [SUM_W-1:0] sr_ext;
   logic [SUM_W-1:0] sc_ext;
   logic [SUM_W-1:0] er_sum;
   logic [SUM_W-1:0] ec_sum;

   assign push_entry = '{len: push_len, sr: push_sr, sc: push_sc, mode: push_mode};
   assign taken      = head_valid_ff && !rsp_stall;

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      if (taken) begin
         if (tail_valid_ff) begin
            head_in       = tail_ff;
            tail_in       = push_entry;
            tail_valid_in = push;
         end else begin
            head_in       = push_entry;
            head_valid_in = push;
         end
      end else if (head_valid_ff) begin
         if (push) begin
            tail_in       = push_entry;
            tail_valid_in = 1'b1;
         end
      end else if (push) begin
         head_in       = push_entry;
         head_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
   end

   assign status = '{head_valid: head_valid_ff, tail_valid: tail_valid_ff};

   always_comb begin
      sr_ext = SUM_W'(head_ff.sr);
      sc_ext = SUM_W'(head_ff.sc);
      er_sum = sr_ext + SUM_W'(head_ff.len) - SUM_W'(1);
      ec_sum = sc_ext + SUM_W'(head_ff.len) - SUM_W'(1);
      rsp_found     = (head_ff.len != '0);
      rsp_start_row = '0;
      rsp_start_col = '0;
      rsp_end_row   = '0;
      rsp_end_col   = '0;
      if (rsp_found) begin
         rsp_start_row = sr_ext[llof_pkg::COORD_W-1:0];
         rsp_start_col = sc_ext[llof_pkg::COORD_W-1:0];
         if (head_ff.mode == llof_pkg::DIR_VERTICAL) begin
            rsp_end_row = er_sum[llof_pkg::COORD_W-1:0];
            rsp_end_col = sc_ext[llof_pkg::COORD_W-1:0];
         end else begin
            rsp_end_row = sr_ext[llof_pkg::COORD_W-1:0];
            rsp_end_col = ec_sum[llof_pkg::COORD_W-1:0];
         end
      end
   end

   assign rsp_valid = head_valid_ff;

endmodule

// File: src/longest_line_of_ones_finder.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_pixel_bit
// rsp       out        rsp_valid/rsp_stall  rsp_found, rsp_start_row/col, rsp_end_row/col
// apb       in/out     psel/penable/pready  paddr, pwdata, pwrite, prdata
//
// One pixel per cycle, back to back, while req_stall is low; the column line memory
// does one read and one write per cycle, with forwarding for a one-column image.
// The frame's last pixel is registered in the run tracker stage, its result in the result queue.
// Reset is synchronous; no memory clearing pass, a fill count stands in.
// req_stall is high during reset and when the two-entry result queue could overflow.
module longest_line_of_ones_finder #(
   parameter int MAX_WIDTH  = llof_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = llof_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   // pixel stream
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_pixel_bit,
   // result stream
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_found,
   output logic [llof_pkg::COORD_W-1:0]    rsp_start_row,
   output logic [llof_pkg::COORD_W-1:0]    rsp_start_col,
   output logic [llof_pkg::COORD_W-1:0]    rsp_end_row,
   output logic [llof_pkg::COORD_W-1:0]    rsp_end_col,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [llof_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [llof_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [llof_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int LEN_W = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
   localparam int MW_W  = $clog2(MAX_WIDTH + 1);
   localparam int MH_W  = $clog2(MAX_HEIGHT + 1);
   localparam int DIM_A = (MW_W > MH_W) ? MW_W : MH_W;
   localparam int DIM_W = ((DIM_A > llof_pkg::CFG_SIZE_W) ? DIM_A : llof_pkg::CFG_SIZE_W) + 1;

   // ---------------------------------------------------------------------
   // Register file
   // ---------------------------------------------------------------------
   llof_pkg::dir_type                 mode_ff;
   logic [llof_pkg::CFG_SIZE_W-1:0]   width_ff;
   logic [llof_pkg::CFG_SIZE_W-1:0]   height_ff;
   llof_pkg::reg_index_type           reg_sel;
   logic                              csr_write;

   assign pready    = 1'b1;
   assign reg_sel   = llof_pkg::reg_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= llof_pkg::DIR_HORIZONTAL;
         width_ff  <= llof_pkg::CFG_SIZE_W'(1);
         height_ff <= llof_pkg::CFG_SIZE_W'(1);
      end else if (csr_write) begin
         case (reg_sel)
            llof_pkg::REG_MODE: begin
               mode_ff <= llof_pkg::dir_type'(pwdata[0]);
            end
            llof_pkg::REG_WIDTH: begin
               width_ff <= pwdata[llof_pkg::CFG_SIZE_W-1:0];
            end
            llof_pkg::REG_HEIGHT: begin
               height_ff <= pwdata[llof_pkg::CFG_SIZE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         llof_pkg::REG_MODE:   prdata = llof_pkg::CSR_DATA_W'(mode_ff);
         llof_pkg::REG_WIDTH:  prdata = llof_pkg::CSR_DATA_W'(width_ff);
         llof_pkg::REG_HEIGHT: prdata = llof_pkg::CSR_DATA_W'(height_ff);
         default:              prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Raster cursor (first stage)
   // ---------------------------------------------------------------------
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [DIM_W-1:0] width_ext, height_ext;
   logic [DIM_W-1:0] width_eff, height_eff;
   logic             row_end, frame_end;
   logic             req_accept;
   llof_pkg::pix_ctrl_type acc_ctrl;

   always_comb begin
      width_ext  = DIM_W'(width_ff);
      height_ext = DIM_W'(height_ff);
      // zero counts as one, oversize clips to the maximum
      if (width_ext == '0)                      width_eff = DIM_W'(1);
      else if (width_ext > DIM_W'(MAX_WIDTH))   width_eff = DIM_W'(MAX_WIDTH);
      else                                      width_eff = width_ext;
      if (height_ext == '0)                     height_eff = DIM_W'(1);
      else if (height_ext > DIM_W'(MAX_HEIGHT)) height_eff = DIM_W'(MAX_HEIGHT);
      else                                      height_eff = height_ext;

      row_end   = (DIM_W'(col_ff) + DIM_W'(1)) >= width_eff;
      frame_end = row_end && ((DIM_W'(row_ff) + DIM_W'(1)) >= height_eff);

      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign acc_ctrl = '{valid:     req_accept,
                       pixel:     req_pixel_bit,
                       first_row: (row_ff == '0),
                       first_col: (col_ff == '0),
                       frame_end: frame_end};

   // ---------------------------------------------------------------------
   // Column memory and run tracker (second stage)
   // ---------------------------------------------------------------------
   logic [LEN_W-1:0]  rd_len;
   logic [RW-1:0]     rd_start;
   logic              wr_en;
   logic [CW-1:0]     wr_col;
   logic [LEN_W-1:0]  wr_len;
   logic [RW-1:0]     wr_start;
   logic              res_push;
   logic [LEN_W-1:0]  res_len;
   logic [RW-1:0]     res_sr;
   logic [CW-1:0]     res_sc;
   llof_pkg::dir_type res_mode;

   llof_col_mem #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_col_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_col   (col_ff),
      .rd_len   (rd_len),
      .rd_start (rd_start),
      .wr_en    (wr_en),
      .wr_col   (wr_col),
      .wr_len   (wr_len),
      .wr_start (wr_start)
   );

   llof_run_track #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_run_track (
      .clock    (clock),
      .reset    (reset),
      .acc_ctrl (acc_ctrl),
      .acc_row  (row_ff),
      .acc_col  (col_ff),
      .mode     (mode_ff),
      .rd_len   (rd_len),
      .rd_start (rd_start),
      .wr_en    (wr_en),
      .wr_col   (wr_col),
      .wr_len   (wr_len),
      .wr_start (wr_start),
      .res_push (res_push),
      .res_len  (res_len),
      .res_sr   (res_sr),
      .res_sc   (res_sc),
      .res_mode (res_mode)
   );

   // ---------------------------------------------------------------------
   // Result queue and input flow control
   // ---------------------------------------------------------------------
   llof_pkg::queue_status_type q_status;
   logic                       q_drain;
   logic [2:0]                 pending;

   llof_res_queue #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_res_queue (
      .clock         (clock),
      .reset         (reset),
      .push          (res_push),
      .push_len      (res_len),
      .push_sr       (res_sr),
      .push_sc       (res_sc),
      .push_mode     (res_mode),
      .status        (q_status),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_found     (rsp_found),
      .rsp_start_row (rsp_start_row),
      .rsp_start_col (rsp_start_col),
      .rsp_end_row   (rsp_end_row),
      .rsp_end_col   (rsp_end_col)
   );

   // results owed after this edge: queued plus in flight, less the one leaving;
   // a new pixel may add one more, and the queue holds two
   assign q_drain    = q_status.head_valid && !rsp_stall;
   assign pending    = 3'(q_status.head_valid) + 3'(q_status.tail_valid) +
                       3'(res_push) - 3'(q_drain);
   assign req_stall  = reset || (pending >= 3'd2);
   assign req_accept = req_valid && !req_stall;

`ifndef SYNTHESIS
   a_stall_needs_result : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   a_frame_end_pushes : assert property (@(posedge clock) disable iff (reset)
      (req_accept && frame_end) |=> res_push)
      else $error("frame end did not produce a result");

   a_queue_no_overflow : assert property (@(posedge clock) disable iff (reset)
      res_push |-> !(q_status.tail_valid && !q_drain))
      else $error("result queue overflow");

   a_empty_is_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_start_row == '0 && rsp_start_col == '0 &&
                                     rsp_end_row == '0 && rsp_end_col == '0))
      else $error("empty frame result has non-zero coordinates");
`endif

endmodule

// File: tb/run_checker.sv
module run_checker #(
   parameter int MAX_WIDTH  = llof_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = llof_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_pixel_bit,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_found,
   input  logic [llof_pkg::COORD_W-1:0]    rsp_start_row,
   input  logic [llof_pkg::COORD_W-1:0]    rsp_start_col,
   input  logic [llof_pkg::COORD_W-1:0]    rsp_end_row,
   input  logic [llof_pkg::COORD_W-1:0]    rsp_end_col,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic                            pready,
   input  logic [llof_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [llof_pkg::CSR_DATA_W-1:0] pwdata,
   output int                              outstanding,
   output int                              mismatches
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                         found;
      logic [llof_pkg::COORD_W-1:0] start_row;
      logic [llof_pkg::COORD_W-1:0] start_col;
      logic [llof_pkg::COORD_W-1:0] end_row;
      logic [llof_pkg::COORD_W-1:0] end_col;
   } run_result_type;

   // shadow registers
   llof_pkg::dir_type mode_q;
   int                width_q;
   int                height_q;

   // line memory and frame state
   int col_len   [MAX_WIDTH];
   int col_start [MAX_WIDTH];
   int row_run;
   int cur_row;
   int cur_col;
   int best_len;
   int best_row;
   int best_col;

   run_result_type longest_run_q[$];
   int             fail_count = 0;

   initial begin
      outstanding = 0;
      mismatches  = 0;
   end

   // earlier start in raster order wins a tie
   task automatic consider_run(input int len, input int sr, input int sc);
      if (len == 0) return;
      if (len > best_len ||
          (len == best_len && (sr < best_row || (sr == best_row && sc < best_col)))) begin
         best_len = len;
         best_row = sr;
         best_col = sc;
      end
   endtask

   task automatic track_pixel(input logic pix);
      int             w;
      int             h;
      int             col;
      int             row;
      int             prev;
      int             hlen;
      int             vlen;
      int             vstart;
      run_result_type res;
      w   = (width_q == 0) ? 1 : ((width_q > MAX_WIDTH) ? MAX_WIDTH : width_q);
      h   = (height_q == 0) ? 1 : ((height_q > MAX_HEIGHT) ? MAX_HEIGHT : height_q);
      col = (cur_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : cur_col;
      row = cur_row;

      prev    = (col == 0) ? 0 : row_run;
      hlen    = pix ? prev + 1 : 0;
      row_run = hlen;

      prev = (row == 0) ? 0 : col_len[col];
      if (pix) begin
         vstart = (prev == 0) ? row : col_start[col];
         vlen   = prev + 1;
      end else begin
         vstart = row;
         vlen   = 0;
      end
      col_len[col]   = vlen;
      col_start[col] = vstart;

      if (mode_q == llof_pkg::DIR_HORIZONTAL)
         consider_run(hlen, row, col + 1 - ((hlen != 0) ? hlen : 1));
      else
         consider_run(vlen, vstart, col);

      if (cur_col + 1 >= w && cur_row + 1 >= h) begin
         res = '0;
         if (best_len != 0) begin
            res.found     = 1'b1;
            res.start_row = llof_pkg::COORD_W'(best_row);
            res.start_col = llof_pkg::COORD_W'(best_col);
            res.end_row   = llof_pkg::COORD_W'((mode_q == llof_pkg::DIR_VERTICAL) ?
                                               best_row + best_len - 1 : best_row);
            res.end_col   = llof_pkg::COORD_W'((mode_q == llof_pkg::DIR_HORIZONTAL) ?
                                               best_col + best_len - 1 : best_col);
         end
         longest_run_q.push_back(res);
         cur_col  = 0;
         cur_row  = 0;
         row_run  = 0;
         best_len = 0;
         best_row = 0;
         best_col = 0;
      end else if (cur_col + 1 >= w) begin
         cur_col = 0;
         cur_row = cur_row + 1;
      end else begin
         cur_col = cur_col + 1;
      end
   endtask

   task automatic check_result();
      run_result_type want;
      run_result_type got;
      got = {rsp_found, rsp_start_row, rsp_start_col, rsp_end_row, rsp_end_col};
      if (longest_run_q.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: result transaction with none pending: found=%0d (%0d,%0d)-(%0d,%0d)",
                     $realtime, got.found, got.start_row, got.start_col, got.end_row, got.end_col);
         return;
      end
      want = longest_run_q.pop_front();
      if (got.found !== want.found || got.start_row !== want.start_row ||
          got.start_col !== want.start_col || got.end_row !== want.end_row ||
          got.end_col !== want.end_col) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: mismatch exp found=%0d (%0d,%0d)-(%0d,%0d) got found=%0d (%0d,%0d)-(%0d,%0d)",
                     $realtime, want.found, want.start_row, want.start_col, want.end_row,
                     want.end_col, got.found, got.start_row, got.start_col, got.end_row,
                     got.end_col);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode_q   = llof_pkg::DIR_HORIZONTAL;
         width_q  = 1;
         height_q = 1;
         for (int i = 0; i < MAX_WIDTH; i++) col_len[i] = 0;
         row_run  = 0;
         cur_row  = 0;
         cur_col  = 0;
         best_len = 0;
         best_row = 0;
         best_col = 0;
         longest_run_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (llof_pkg::reg_index_type'(paddr[llof_pkg::CSR_ADDR_W-1:2]))
               llof_pkg::REG_MODE:   mode_q   = llof_pkg::dir_type'(pwdata[0]);
               llof_pkg::REG_WIDTH:  width_q  = int'(pwdata[llof_pkg::CFG_SIZE_W-1:0]);
               llof_pkg::REG_HEIGHT: height_q = int'(pwdata[llof_pkg::CFG_SIZE_W-1:0]);
               default: ;
            endcase
         end
         if (req_valid && !req_stall) track_pixel(req_pixel_bit);
         if (rsp_valid && !rsp_stall) check_result();
      end
      outstanding <= longest_run_q.size();
      mismatches  <= fail_count;
   end

endmodule

// File: tb/testbench.sv
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS  = 1600;
   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_HOLD     = 300;  // receiver hold-off, in cycles
   localparam int TALL_ROWS     = 300;  // rows of the tall one-column frame

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic                            req_pixel_bit;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic                            rsp_found;
   logic [llof_pkg::COORD_W-1:0]    rsp_start_row;
   logic [llof_pkg::COORD_W-1:0]    rsp_start_col;
   logic [llof_pkg::COORD_W-1:0]    rsp_end_row;
   logic [llof_pkg::COORD_W-1:0]    rsp_end_col;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [llof_pkg::CSR_ADDR_W-1:0] paddr;
   logic [llof_pkg::CSR_DATA_W-1:0] pwdata;
   logic [llof_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   int outstanding;
   int mismatches;

   // stimulus-side knobs shared with the receiver process
   logic              calm;          // no random idling on either side while set
   int                hold_ticket;   // bumped to ask the receiver for one long hold-off
   llof_pkg::dir_type mode_now;      // mode last written, for mid-frame flips
   int                random_items;
   int                frame_no;

   longest_line_of_ones_finder u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel_bit (req_pixel_bit),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_found     (rsp_found),
      .rsp_start_row (rsp_start_row),
      .rsp_start_col (rsp_start_col),
      .rsp_end_row   (rsp_end_row),
      .rsp_end_col   (rsp_end_col),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   run_checker u_run_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel_bit (req_pixel_bit),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_found     (rsp_found),
      .rsp_start_row (rsp_start_row),
      .rsp_start_col (rsp_start_col),
      .rsp_end_row   (rsp_end_row),
      .rsp_end_col   (rsp_end_col),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .outstanding   (outstanding),
      .mismatches    (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // mostly back to back or short gaps, now and then a long one
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // image side: mostly small, some medium, few wide
   function automatic int pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 6);
      if (r < 92) return $urandom_range(7, 16);
      return $urandom_range(17, 40);
   endfunction

   // One pixel transaction. Valid stays up across back-to-back transactions, so
   // it is only dropped when a gap is wanted; payload holds while stalled.
   task automatic send_pixel(input logic pix);
      int gap;
      gap = calm ? 0 : idle_span();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pixel_bit <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // MSB first
   task automatic send_bits(input logic [15:0] bits, input int n);
      for (int i = n - 1; i >= 0; i--) send_pixel(bits[i]);
   endtask

   // Stop offering, wait until every pending result transaction has come out,
   // then wait out SETTLE_CYCLES so a half-done frame is at rest too.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup phase, access phase, then idle; the write lands on the
   // edge that ends the access phase
   task automatic write_reg(input llof_pkg::reg_index_type idx, input int value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= llof_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input llof_pkg::dir_type m, input int w, input int h);
      settle();
      write_reg(llof_pkg::REG_MODE, int'(m));
      write_reg(llof_pkg::REG_WIDTH, w);
      write_reg(llof_pkg::REG_HEIGHT, h);
      mode_now = m;
   endtask

   // n random pixels at the given percentage of ones; optional mode flip
   // part-way through the frame (flip_at < 0 means none)
   task automatic send_image(input int n, input int density, input int flip_at);
      for (int i = 0; i < n; i++) begin
         if (i == flip_at) begin
            settle();
            mode_now = (mode_now == llof_pkg::DIR_VERTICAL) ? llof_pkg::DIR_HORIZONTAL :
                                                              llof_pkg::DIR_VERTICAL;
            write_reg(llof_pkg::REG_MODE, int'(mode_now));
         end
         send_pixel($urandom_range(0, 99) < density);
      end
   endtask

   // receiver: random stall, with one long hold-off on request
   initial begin
      int stall_left;
      int open_left;
      int tickets_seen;
      stall_left   = 0;
      open_left    = 0;
      tickets_seen = 0;
      rsp_stall   <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ticket != tickets_seen) begin
            tickets_seen = hold_ticket;
            stall_left   = LONG_HOLD;
         end else if (stall_left == 0 && open_left == 0) begin
            stall_left = calm ? 0 : idle_span();
            open_left  = $urandom_range(1, 8);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (open_left > 0) open_left--;
         end
      end
   end

   // hard limit on the whole run
   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

   // stimulus and verdict
   initial begin
      int m;
      int w;
      int h;
      int n;
      int k;
      int extra;
      int density;
      int flip_at;

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_pixel_bit <= 1'b0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      calm          = 1'b0;
      hold_ticket   = 0;
      mode_now      = llof_pkg::DIR_HORIZONTAL;
      random_items  = 0;
      frame_no      = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // reset sizes give one-pixel frames: empty image, then a lone set pixel
      send_pixel(1'b0);
      send_pixel(1'b1);

      // horizontal tie: row 0 cols 0..1 against row 1 cols 1..2, first one wins
      configure(llof_pkg::DIR_HORIZONTAL, 3, 2);
      send_bits(16'b110011, 6);

      // vertical tie: col 0 rows 0..1 against col 1 rows 1..2
      configure(llof_pkg::DIR_VERTICAL, 2, 3);
      send_bits(16'b101101, 6);

      // zero sizes count as one
      configure(llof_pkg::DIR_HORIZONTAL, 0, 0);
      send_pixel(1'b1);

      // width shrunk under the cursor, then mode flipped, both mid-frame
      configure(llof_pkg::DIR_HORIZONTAL, 4, 2);
      send_bits(16'b111, 3);
      settle();
      write_reg(llof_pkg::REG_WIDTH, 2);
      send_pixel(1'b1);
      settle();
      mode_now = llof_pkg::DIR_VERTICAL;
      write_reg(llof_pkg::REG_MODE, int'(mode_now));
      send_bits(16'b11, 2);

      // --- random ---
      while (random_items < RANDOM_ITEMS) begin
         frame_no++;
         calm = ($urandom_range(0, 3) == 0);
         if (frame_no == 1) begin
            // one-pixel frames against a long receiver hold-off: the result
            // queue fills and the input has to stall
            configure(llof_pkg::DIR_HORIZONTAL, 1, 1);
            calm = 1'b1;
            hold_ticket++;
            send_image(40, 50, -1);
            random_items += 40;
         end else if (frame_no == 2) begin
            // widest row, width above the maximum clamps: run spans cols 0..1023
            configure(llof_pkg::DIR_HORIZONTAL, 2047, 0);
            send_image(llof_pkg::DEF_MAX_WIDTH, 100, -1);
            random_items += llof_pkg::DEF_MAX_WIDTH;
         end else if (frame_no == 3) begin
            // tall column, zero width counts as one: one long vertical run
            configure(llof_pkg::DIR_VERTICAL, 0, TALL_ROWS);
            send_image(TALL_ROWS, 100, -1);
            random_items += TALL_ROWS;
         end else begin
            if (frame_no % 16 == 0) settle();   // sender waits for all results
            m = $urandom_range(0, 1);
            w = pick_size();
            h = pick_size();
            configure(llof_pkg::dir_type'(m), w, h);
            n = w * h;
            case ($urandom_range(0, 5))
               0:       density = 0;
               1:       density = 100;
               2:       density = 15;
               3:       density = 85;
               default: density = 50;
            endcase
            if (n > 1 && $urandom_range(0, 9) == 0) begin
               // broken frame: sizes rewritten under the cursor, then a 1x1
               // setting closes whatever frame is open
               k     = $urandom_range(1, n - 1);
               extra = $urandom_range(0, 3);
               send_image(k, density, -1);
               settle();
               write_reg(llof_pkg::REG_WIDTH, $urandom_range(1, w));
               write_reg(llof_pkg::REG_HEIGHT, $urandom_range(1, h));
               send_image(extra, density, -1);
               configure(mode_now, 1, 1);
               send_pixel(1'($urandom_range(0, 1)));
               random_items += k + extra + 1;
            end else begin
               flip_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
               send_image(n, density, flip_at);
               random_items += n;
            end
         end
      end

      // drain, then verdict
      calm = 1'b0;
      settle();
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/llof_pkg.sv
src/llof_col_mem.sv
src/llof_run_track.sv
src/llof_res_queue.sv
src/longest_line_of_ones_finder.sv
tb/run_checker.sv
tb/testbench.sv
